### rtl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    // pipeline depth, one bit per register stage
    localparam int NUM_STAGES = 5;

    localparam int FIELD_W     = 9;
    localparam int COLOR_W     = 8;
    localparam int SECTOR_DEG  = 60;
    localparam int NUM_SECTORS = 6;

    // per-channel chroma weight, range -60..60
    localparam int WEIGHT_W = 7;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef weight_t [2:0] weight_vec_t;

    localparam weight_t WEIGHT_FULL = weight_t'(SECTOR_DEG);
    localparam weight_t WEIGHT_NONE = weight_t'(-SECTOR_DEG);
    localparam weight_t WEIGHT_MID  = weight_t'(SECTOR_DEG / 2);

    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;

    // lightness times 120 fits in 16 bits
    localparam int LIG_SCALE_W = 16;

    // final divide by 120: drop 3 bits, then multiply by reciprocal of 15
    localparam int QUOT_W      = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_PROD_W = QUOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_15 = 13'd4370;
    localparam int RECIP_SHIFT = 16;
    // 256 * 120: quotient would exceed 255 at or above this
    localparam int CLIP_LIMIT  = 30720;
    localparam logic [COLOR_W-1:0] COLOR_MAX = 8'd255;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } stage_ctl_t;

    // width of one - |2l - one|
    function automatic int diff_width(int frac);
        return ((frac > 10) ? frac : 10) + 2;
    endfunction

    // width of the chroma product
    function automatic int chroma_width(int frac);
        return diff_width(frac) + FIELD_W + 1;
    endfunction

endpackage

### rtl/hsl2rgb_in_if.sv
interface hsl2rgb_in_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue_deg;
    logic [8:0] sat_level;
    logic [8:0] light_level;

    modport source (output valid, hue_deg, sat_level, light_level, input ready);
    modport sink (input valid, hue_deg, sat_level, light_level, output ready);
endinterface

### rtl/hsl2rgb_out_if.sv
interface hsl2rgb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/hsl2rgb_front.sv
module hsl2rgb_front
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    localparam int DW = diff_width(FRAC_BITS),
    localparam int CW = chroma_width(FRAC_BITS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stage_ctl_t           ctl,
    input  logic [FIELD_W-1:0]   hue_deg,
    input  logic [FIELD_W-1:0]   sat_level,
    input  logic [FIELD_W-1:0]   light_level,
    output logic signed [CW-1:0] chroma,
    output logic [FIELD_W-1:0]   lig,
    output weight_vec_t          weights
);

    localparam logic signed [DW-1:0] ONE_S = DW'(1 << FRAC_BITS);
    localparam logic [FIELD_W-1:0] GRAY_HUE = FIELD_W'(NUM_SECTORS * SECTOR_DEG);

    logic signed [DW-1:0] twice_l;
    logic signed [DW-1:0] dev_raw;
    logic signed [DW-1:0] dev;
    logic signed [DW-1:0] diff_next;
    logic signed [DW-1:0] diff_reg;
    logic [FIELD_W-1:0]   sat_reg;
    logic [FIELD_W-1:0]   lig1_reg;
    weight_vec_t          w_next;
    weight_vec_t          w1_reg;

    logic [2:0]           sector;
    logic [FIELD_W-1:0]   offs;
    logic [5:0]           tri_w;
    weight_t              xw;

    logic signed [CW-1:0] diff_ext;
    logic signed [CW-1:0] sat_ext;
    logic signed [CW-1:0] chroma_next;
    logic signed [CW-1:0] chroma_reg;
    logic [FIELD_W-1:0]   lig2_reg;
    weight_vec_t          w2_reg;

    // stage 1: lightness term and sector weights
    assign twice_l   = $signed({{(DW-FIELD_W-1){1'b0}}, light_level, 1'b0});
    assign dev_raw   = twice_l - ONE_S;
    assign dev       = dev_raw[DW-1] ? -dev_raw : dev_raw;
    assign diff_next = ONE_S - dev;

    always_comb
    begin
        sector = 3'(NUM_SECTORS);
        for (int k = NUM_SECTORS - 1; k >= 0; k--)
        begin
            if (hue_deg < FIELD_W'((k + 1) * SECTOR_DEG))
            begin
                sector = 3'(k);
            end
        end
    end

    // offset inside the sector; rising ramp in even sectors, falling in odd
    assign offs  = hue_deg - FIELD_W'(32'(sector) * SECTOR_DEG);
    assign tri_w = sector[0] ? (6'(SECTOR_DEG) - offs[5:0]) : offs[5:0];
    assign xw    = ($signed({1'b0, tri_w}) - WEIGHT_MID) <<< 1;

    always_comb
    begin
        w_next = {3{WEIGHT_NONE}};
        case (sector)
            3'd0:
            begin
                w_next[CHAN_RED]   = WEIGHT_FULL;
                w_next[CHAN_GREEN] = xw;
            end
            3'd1:
            begin
                w_next[CHAN_RED]   = xw;
                w_next[CHAN_GREEN] = WEIGHT_FULL;
            end
            3'd2:
            begin
                w_next[CHAN_GREEN] = WEIGHT_FULL;
                w_next[CHAN_BLUE]  = xw;
            end
            3'd3:
            begin
                w_next[CHAN_GREEN] = xw;
                w_next[CHAN_BLUE]  = WEIGHT_FULL;
            end
            3'd4:
            begin
                w_next[CHAN_RED]   = xw;
                w_next[CHAN_BLUE]  = WEIGHT_FULL;
            end
            3'd5:
            begin
                w_next[CHAN_RED]   = WEIGHT_FULL;
                w_next[CHAN_BLUE]  = xw;
            end
            default:
            begin
                w_next = {3{WEIGHT_NONE}};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            diff_reg <= diff_next;
            sat_reg  <= sat_level;
            lig1_reg <= light_level;
            w1_reg   <= w_next;
        end
    end

    // stage 2: chroma, scaled by one squared
    assign diff_ext    = CW'(diff_reg);
    assign sat_ext     = CW'($signed({1'b0, sat_reg}));
    assign chroma_next = diff_ext * sat_ext;

    always_ff @(posedge clk)
    begin
        if (ctl.load[1])
        begin
            chroma_reg <= chroma_next;
            lig2_reg   <= lig1_reg;
            w2_reg     <= w1_reg;
        end
    end

    assign chroma  = chroma_reg;
    assign lig     = lig2_reg;
    assign weights = w2_reg;

    a_gray_weights: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load[0] && hue_deg >= GRAY_HUE) |=>
            (w1_reg[CHAN_RED] == WEIGHT_NONE && w1_reg[CHAN_GREEN] == WEIGHT_NONE
             && w1_reg[CHAN_BLUE] == WEIGHT_NONE))
        else $error("gray hue gave a non-zero chroma weight");

    a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load[0] |=> (diff_reg <= ONE_S))
        else $error("chroma factor above one");

endmodule

### rtl/hsl2rgb_chan.sv
module hsl2rgb_chan
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8,
    localparam int CW = chroma_width(FRAC_BITS)
)
(
    input  logic                 clk,
    input  stage_ctl_t           ctl,
    input  logic signed [CW-1:0] chroma,
    input  logic [FIELD_W-1:0]   lig,
    input  weight_t              weight,
    output logic [COLOR_W-1:0]   color
);

    localparam int PW = CW + WEIGHT_W;
    localparam int BW = LIG_SCALE_W + FRAC_BITS;
    localparam int NW = ((PW > BW) ? PW : BW) + 1;
    localparam int SW = ((NW + 8) > (2 * FRAC_BITS + 17)) ? (NW + 8) : (2 * FRAC_BITS + 17);

    logic signed [PW-1:0]     chroma_ext;
    logic signed [PW-1:0]     weight_ext;
    logic signed [PW-1:0]     prod;
    logic [LIG_SCALE_W-1:0]   lig120;
    logic [BW-1:0]            base_u;
    logic signed [NW-1:0]     base_s;
    logic signed [NW-1:0]     num_next;
    logic signed [NW-1:0]     num_reg;

    logic signed [SW-1:0]     scaled;
    logic signed [SW-1:0]     xs;
    logic                     pos;
    logic                     zero_next;
    logic                     clip_next;
    logic [QUOT_W-1:0]        y_next;
    logic                     zero_reg;
    logic                     clip_reg;
    logic [QUOT_W-1:0]        y_reg;

    logic [RECIP_PROD_W-1:0]  qprod;
    logic [COLOR_W-1:0]       color_next;
    logic [COLOR_W-1:0]       color_reg;

    // stage 3: numerator over 120 * one^2
    assign chroma_ext = PW'(chroma);
    assign weight_ext = PW'(weight);
    assign prod       = chroma_ext * weight_ext;
    assign lig120     = (LIG_SCALE_W'(lig) << 7) - (LIG_SCALE_W'(lig) << 3);
    assign base_u     = BW'(lig120) << FRAC_BITS;
    assign base_s     = $signed(NW'(base_u));
    assign num_next   = NW'(prod) + base_s;

    always_ff @(posedge clk)
    begin
        if (ctl.load[2])
        begin
            num_reg <= num_next;
        end
    end

    // stage 4: times 255, drop one^2, flag the clamped cases
    assign scaled    = (SW'(num_reg) <<< 8) - SW'(num_reg);
    assign xs        = scaled >>> (2 * FRAC_BITS);
    assign pos       = !num_reg[NW-1] && (num_reg != '0);
    assign zero_next = !pos;
    assign clip_next = pos && (xs >= SW'(CLIP_LIMIT));
    assign y_next    = xs[QUOT_W+2:3];

    always_ff @(posedge clk)
    begin
        if (ctl.load[3])
        begin
            zero_reg <= zero_next;
            clip_reg <= clip_next;
            y_reg    <= y_next;
        end
    end

    // stage 5: divide by 15 through the reciprocal
    assign qprod = RECIP_PROD_W'(y_reg) * RECIP_PROD_W'(RECIP_15);

    always_comb
    begin
        if (zero_reg)
        begin
            color_next = '0;
        end
        else if (clip_reg)
        begin
            color_next = COLOR_MAX;
        end
        else
        begin
            color_next = qprod[RECIP_SHIFT +: COLOR_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load[4])
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

### rtl/hsl2rgb_to_rgb_converter_unit.sv
// channel  dir   payload                              handshake
// hsl      in    hue_deg, sat_level, light_level      valid / ready
// rgb      out   red_out, green_out, blue_out         valid / ready
//
// five register stages; after its transaction on hsl a pixel's valid bit moves
// through v_reg from the first stage to the last, and rgb.valid is the last bit;
// a new pixel can be taken every cycle while hsl.ready is high
// each stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so bubbles close up while the output waits
// rst_n clears the valid bits only; datapath registers are not reset
// a stalled rgb fills the pipe, after which hsl.ready drops
module hsl_to_rgb_converter_unit
    import hsl2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    hsl2rgb_in_if.sink        hsl,
    hsl2rgb_out_if.source     rgb
);

    localparam int CW = chroma_width(FRAC_BITS);

    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] v_next;
    logic [NUM_STAGES-1:0] rdy;
    stage_ctl_t            ctl;

    logic signed [CW-1:0]  chroma;
    logic [FIELD_W-1:0]    lig;
    weight_vec_t           weights;
    logic [2:0][COLOR_W-1:0] colors;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || rgb.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign ctl.load = rdy;

    always_comb
    begin
        v_next = v_reg;
        if (rdy[0])
        begin
            v_next[0] = hsl.valid;
        end
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (rdy[i])
            begin
                v_next[i] = v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    hsl2rgb_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .hue_deg     (hsl.hue_deg),
        .sat_level   (hsl.sat_level),
        .light_level (hsl.light_level),
        .chroma      (chroma),
        .lig         (lig),
        .weights     (weights)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        hsl2rgb_chan #(
            .FRAC_BITS (FRAC_BITS)
        ) u_chan (
            .clk    (clk),
            .ctl    (ctl),
            .chroma (chroma),
            .lig    (lig),
            .weight (weights[c]),
            .color  (colors[c])
        );
    end

    assign hsl.ready     = rdy[0];
    assign rgb.valid     = v_reg[NUM_STAGES-1];
    assign rgb.red_out   = colors[CHAN_RED];
    assign rgb.green_out = colors[CHAN_GREEN];
    assign rgb.blue_out  = colors[CHAN_BLUE];

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((&v_reg) && !rgb.ready) |-> !hsl.ready)
        else $error("input taken while the pipe is full and stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (hsl.valid && hsl.ready) |=> v_reg[0])
        else $error("accepted transaction lost at the first stage");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && rgb.ready && !v_reg[NUM_STAGES-2]) |=> !rgb.valid)
        else $error("output repeated after its transaction");

endmodule
